// ----- hw/rtl/rrif_pkg.sv -----
// ----------------------------------------------------------------------------
// rrif_pkg: shared types and constants of the round-robin interrupt firer
// Request codes, FSM states, result and memory-port structs, bit scanner.
// ----------------------------------------------------------------------------
package rrif_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_WORDS     = 16;
  localparam int DEF_NUM_WORDS = 16;
  localparam int WIDX_W        = 4;   // word index field width
  localparam int BIT_W         = 5;   // bit position inside one word
  localparam int IRQ_W         = 9;   // interrupt number width
  localparam int PERIOD_W      = 16;
  localparam int REQ_W         = 3;
  localparam int IN_DATA_W     = 40;  // 36 payload bits, padded to bytes
  localparam int OUT_DATA_W    = 48;  // 43 payload bits, padded to bytes

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_SET   = 3'd1,
    REQ_CLR   = 3'd2,
    REQ_READ  = 3'd3,
    REQ_ERET  = 3'd4
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // One result beat, fire in the lowest bit
  typedef struct packed {
    logic [WORD_BITS-1:0] read_data;
    logic                 none_enabled;
    logic [IRQ_W-1:0]     irq_number;
    logic                 fire;
  } res_t;

  // Enable memory port request
  typedef struct packed {
    logic                 we;
    logic [WIDX_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WIDX_W-1:0]    raddr;
  } mem_req_t;

  // Position of the lowest set bit (zero when none is set)
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

// ----- hw/rtl/rrif_enable_ram.sv -----
// ----------------------------------------------------------------------------
// rrif_enable_ram: enable word memory
// One write and one read port, registered read; per-word valid bits make
// never-written words read as zero after reset.
// ----------------------------------------------------------------------------
module rrif_enable_ram import rrif_pkg::*; #(
  parameter int NUM_WORDS = DEF_NUM_WORDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;

  // Storage array, payload only
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  // Valid bits and read-side valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr[AW-1:0]] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr[AW-1:0]];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- hw/rtl/round_robin_interrupt_firer.sv -----
// ----------------------------------------------------------------------------
// round_robin_interrupt_firer: round-robin interrupt enable file and firer
// Enable words, tick prescaler and a word-serial round-robin search.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser holds the request kind (tick, set-enable,
//   clear-enable, enable read, exception return), tdata the word index and
//   the write mask. m_axis returns exactly one result beat per request.
//   cfg_we_i/cfg_wdata_i write the tick period; only while the block is idle.
// Sequencing:
//   A request is taken in ST_IDLE and its result is assembled in res_q and
//   loaded into the output register from ST_EMIT (set/clear/read first pass
//   ST_ACCESS for the memory read); no new request is taken until then.
//   A tick that starts a firing attempt walks the enable memory one word per
//   cycle through its single read port: NUM_WORDS + 1 reads at most.
// Reset:
//   All enables clear at once through per-word valid bits, pointer and
//   prescaler go to zero, firing is enabled, the period is 1000 ticks.
// Stall:
//   A new request is taken while a result waits in the output register; the
//   block holds its next result until the output register frees up.
// ----------------------------------------------------------------------------
module round_robin_interrupt_firer import rrif_pkg::*; #(
  parameter int NUM_WORDS = DEF_NUM_WORDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config: tick_period
  input  logic                  cfg_we_i,
  input  logic [PERIOD_W-1:0]   cfg_wdata_i,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // word_index[3:0], write_value[35:4]
  input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type[2:0]
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // fire[0], irq_number[9:1],
                                               // none_enabled[10], read_data[42:11]
);

  localparam int TOTAL  = NUM_WORDS * WORD_BITS;
  localparam int STEP_W = $clog2(NUM_WORDS + 1);

  state_e               state_q, state_d;
  logic [REQ_W-1:0]     req_q, req_d;
  logic [WIDX_W-1:0]    idx_q, idx_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  res_t                 res_q, res_d;
  logic [IRQ_W-1:0]     ptr_q, ptr_d;
  logic [PERIOD_W-1:0]  tick_q, tick_d;
  logic [PERIOD_W-1:0]  period_q;
  logic                 fire_en_q, fire_en_d;
  logic [WIDX_W-1:0]    cur_q, cur_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 out_valid_q;
  res_t                 out_q;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [PERIOD_W:0]    tick_inc;
  logic [WIDX_W-1:0]    in_idx;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] masked;
  logic [IRQ_W-1:0]     hit_irq;
  logic [IRQ_W:0]       hit_next;

  rrif_enable_ram #(
    .NUM_WORDS(NUM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_idx        = s_axis_tdata[WIDX_W-1:0];
  assign tick_inc      = {1'b0, tick_q} + 1'b1;

  // Search window: first word from the pointer bit up, last word below it
  assign hi_mask   = {WORD_BITS{1'b1}} << ptr_q[BIT_W-1:0];
  always_comb begin
    if (step_q == '0) begin
      scan_mask = hi_mask;
    end else if (step_q == STEP_W'(NUM_WORDS)) begin
      scan_mask = ~hi_mask;
    end else begin
      scan_mask = '1;
    end
  end
  assign masked   = rdata & scan_mask;
  assign hit_irq  = {cur_q, first_set(masked)};
  assign hit_next = {1'b0, hit_irq} + 1'b1;

  // Sequencer: next state, memory requests, result assembly
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    val_d     = val_q;
    res_d     = res_q;
    ptr_d     = ptr_q;
    tick_d    = tick_q;
    fire_en_d = fire_en_q;
    cur_d     = cur_q;
    step_d    = step_q;
    mem_req   = '0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = s_axis_tuser;
          idx_d   = in_idx;
          val_d   = s_axis_tdata[WIDX_W +: WORD_BITS];
          res_d   = '0;
          state_d = ST_EMIT;
          case (s_axis_tuser)
            REQ_TICK: begin
              if (tick_inc >= {1'b0, period_q}) begin
                tick_d = '0;
                if (fire_en_q) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = ptr_q[IRQ_W-1 -: WIDX_W];
                  cur_d         = ptr_q[IRQ_W-1 -: WIDX_W];
                  step_d        = '0;
                  state_d       = ST_SCAN;
                end
              end else begin
                tick_d = tick_inc[PERIOD_W-1:0];
              end
            end
            REQ_SET, REQ_CLR, REQ_READ: begin
              // out-of-range words are ignored and read as zero
              if ({1'b0, in_idx} < (WIDX_W + 1)'(NUM_WORDS)) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_idx;
                state_d       = ST_ACCESS;
              end
            end
            REQ_ERET: begin
              fire_en_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Word is back from memory: modify and write, or report it.
      // The write lands before any later read can issue.
      ST_ACCESS: begin
        case (req_q)
          REQ_SET: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_q;
            mem_req.wdata = rdata | val_q;
          end
          REQ_CLR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_q;
            mem_req.wdata = rdata & ~val_q;
          end
          REQ_READ: begin
            res_d.read_data = rdata;
          end
          default: begin
          end
        endcase
        state_d = ST_EMIT;
      end

      // One word per cycle, wrapping round to the start word
      ST_SCAN: begin
        if (masked != '0) begin
          res_d.fire       = 1'b1;
          res_d.irq_number = hit_irq;
          ptr_d     = (hit_next == (IRQ_W + 1)'(TOTAL)) ? '0 : hit_next[IRQ_W-1:0];
          fire_en_d = 1'b0;
          state_d   = ST_EMIT;
        end else if (step_q == STEP_W'(NUM_WORDS)) begin
          res_d.none_enabled = 1'b1;
          state_d            = ST_EMIT;
        end else begin
          step_d        = step_q + 1'b1;
          cur_d         = (cur_q == WIDX_W'(NUM_WORDS - 1)) ? '0 : cur_q + 1'b1;
          mem_req.re    = 1'b1;
          mem_req.raddr = cur_d;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      tick_q      <= '0;
      fire_en_q   <= 1'b1;
      period_q    <= PERIOD_RST;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cur_q       <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      tick_q    <= tick_d;
      fire_en_q <= fire_en_d;
      step_q    <= step_d;
      cur_q     <= cur_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    val_q <= val_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), out_q};

  // Checks
  a_fire_xor_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.fire && out_q.none_enabled))
    else $error("fire and none_enabled both set");

  a_irq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.fire) |-> (out_q.irq_number == '0))
    else $error("irq_number without fire");

  a_fire_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_q.fire) |-> !fire_en_q)
    else $error("firing still enabled after fire");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (step_q <= STEP_W'(NUM_WORDS)))
    else $error("scan ran past the wrap word");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < (IRQ_W + 1)'(TOTAL))
    else $error("scan pointer out of range");

endmodule
